### src/first_fit_range_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH

// Checked property, switched off while reset is held
`define FFRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define FFRA_NEVER(lbl, cond, msg) \
  `FFRA_ASSERT(lbl, !(cond), msg)

`endif

### src/ffra_pkg.sv
package ffra_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned EntryW     = 64;

  // capacity growth: 6/5 of the end, taken as end + end/5;
  // end/5 is (end * ceil(2^34/5)) >> 34, exact for any 32-bit end
  localparam logic [31:0] Div5Recip  = 32'hCCCC_CCCD;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StZero    = 3'd1,
    StAlready = 3'd2,
    StUnknown = 3'd3,
    StFull    = 3'd4
  } status_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [EntryW-1:0] pack_entry(logic [31:0] off, logic [31:0] sz);
    return {off, sz};
  endfunction

endpackage

### src/ffra_ram.sv
module ffra_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/ffra_div5.sv
module ffra_div5 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffra_pkg::div_req_t  req_i,
  output ffra_pkg::div_rsp_t  rsp_o
);
  import ffra_pkg::*;

  logic [63:0] prod;
  logic [31:0] quo_q, quo_d;
  logic        done_q, done_d;

  // divide by five as a reciprocal multiply, result in the cycle after start
  always_comb begin
    prod   = {32'd0, req_i.dividend} * {32'd0, Div5Recip};
    quo_d  = quo_q;
    done_d = req_i.start;
    if (req_i.start) begin
      quo_d = {2'b00, prod[63:34]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### src/first_fit_range_allocator.sv
// Channel  | Direction | Handshake                 | Payload
// in       | input     | in_valid_i / in_ready_o   | command_i, block_size_i, block_offset_i
// out      | output    | out_valid_o / out_ready_i | status_o, out_offset_o, out_size_o,
//          |           |                           | grew_o, capacity_now_o
//
// One transaction at a time. A zero-size allocate goes straight to the
// response; any other request scans both tables once, then commits in
// S_DECIDE. An allocate that raises capacity also waits in S_GROW for the
// divide-by-five reciprocal multiply.
// Reset clears valid bits, heap end and capacity at once; table contents
// need no clearing. A result waiting on out_ready_i holds the next one back.
module first_fit_range_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] block_size_i,
  input  logic [31:0] block_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_offset_o,
  output logic [31:0] out_size_o,
  output logic        grew_o,
  output logic [31:0] capacity_now_o
);
  import ffra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_GROW, S_RESP
  } state_e;

  state_e state_q, state_d;

  // request
  logic        cmd_q, cmd_d;
  logic [31:0] size_q, size_d, off_q, off_d;

  // scan control
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            chk_q, chk_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;

  // allocate trackers
  logic            best_hit_q, best_hit_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [31:0]     best_off_q, best_off_d, best_sz_q, best_sz_d;
  logic            uslot_hit_q, uslot_hit_d;
  logic [IdxW-1:0] uslot_q, uslot_d;

  // free trackers
  logic            fhit_q, fhit_d;
  logic            uhit_q, uhit_d;
  logic [IdxW-1:0] uidx_q, uidx_d;
  logic            pred_hit_q, pred_hit_d;
  logic [IdxW-1:0] pred_idx_q, pred_idx_d;
  logic [31:0]     pred_off_q, pred_off_d, pred_sz_q, pred_sz_d;
  logic            succ_hit_q, succ_hit_d;
  logic [IdxW-1:0] succ_idx_q, succ_idx_d;
  logic [31:0]     succ_sz_q, succ_sz_d;
  logic            fslot_hit_q, fslot_hit_d;
  logic [IdxW-1:0] fslot_q, fslot_d;

  // architectural state
  logic [TableDepth-1:0] free_valid_q, free_valid_d;
  logic [TableDepth-1:0] used_valid_q, used_valid_d;
  logic [31:0]           heap_end_q, heap_end_d;
  logic [31:0]           capacity_q, capacity_d;

  // result staging and output register
  status_e     st_q, st_d;
  logic [31:0] roff_q, roff_d, rsz_q, rsz_d;
  logic        rgrew_q, rgrew_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_st_q, out_st_d;
  logic [31:0] out_off_q, out_off_d, out_sz_q, out_sz_d, out_cap_q, out_cap_d;
  logic        out_grew_q, out_grew_d;

  // memories
  logic              free_we, used_we;
  logic [IdxW-1:0]   free_waddr, used_waddr, rd_addr;
  logic [EntryW-1:0] free_wdata, used_wdata, free_rdata, used_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // scan datapath
  logic        fv, uv;
  logic [31:0] fo, fs;
  logic [32:0] fend, req_end, app_end, grow_sum;
  logic [31:0] pred_sum;

  assign rd_addr = rd_cnt_q[IdxW-1:0];

  ffra_ram #(.Width(EntryW), .Depth(TableDepth)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .raddr_i (rd_addr),
    .rdata_o (free_rdata)
  );

  ffra_ram #(.Width(EntryW), .Depth(TableDepth)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (rd_addr),
    .rdata_o (used_rdata)
  );

  ffra_div5 u_div5 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign fv       = free_valid_q[chk_idx_q];
  assign uv       = used_valid_q[chk_idx_q];
  assign fo       = free_rdata[63:32];
  assign fs       = free_rdata[31:0];
  assign fend     = {1'b0, fo} + {1'b0, fs};
  assign req_end  = {1'b0, off_q} + {1'b0, size_q};
  assign app_end  = {1'b0, heap_end_q} + {1'b0, size_q};
  assign grow_sum = {1'b0, heap_end_q} + {1'b0, div_rsp.quotient};
  assign pred_sum = pred_sz_q + size_q + (succ_hit_q ? succ_sz_q : 32'd0);

  assign in_ready_o = (state_q == S_IDLE);

  // sequencer: scan, decide and commit, grow, respond
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    size_d       = size_q;
    off_d        = off_q;
    rd_cnt_d     = rd_cnt_q;
    chk_d        = 1'b0;
    chk_idx_d    = chk_idx_q;
    best_hit_d   = best_hit_q;
    best_idx_d   = best_idx_q;
    best_off_d   = best_off_q;
    best_sz_d    = best_sz_q;
    uslot_hit_d  = uslot_hit_q;
    uslot_d      = uslot_q;
    fhit_d       = fhit_q;
    uhit_d       = uhit_q;
    uidx_d       = uidx_q;
    pred_hit_d   = pred_hit_q;
    pred_idx_d   = pred_idx_q;
    pred_off_d   = pred_off_q;
    pred_sz_d    = pred_sz_q;
    succ_hit_d   = succ_hit_q;
    succ_idx_d   = succ_idx_q;
    succ_sz_d    = succ_sz_q;
    fslot_hit_d  = fslot_hit_q;
    fslot_d      = fslot_q;
    free_valid_d = free_valid_q;
    used_valid_d = used_valid_q;
    heap_end_d   = heap_end_q;
    capacity_d   = capacity_q;
    st_d         = st_q;
    roff_d       = roff_q;
    rsz_d        = rsz_q;
    rgrew_d      = rgrew_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_st_d     = out_st_q;
    out_off_d    = out_off_q;
    out_sz_d     = out_sz_q;
    out_grew_d   = out_grew_q;
    out_cap_d    = out_cap_q;
    free_we      = 1'b0;
    free_waddr   = '0;
    free_wdata   = '0;
    used_we      = 1'b0;
    used_waddr   = '0;
    used_wdata   = '0;
    div_req      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = command_i;
          size_d      = block_size_i;
          off_d       = block_offset_i;
          rd_cnt_d    = '0;
          best_hit_d  = 1'b0;
          uslot_hit_d = 1'b0;
          fhit_d      = 1'b0;
          uhit_d      = 1'b0;
          pred_hit_d  = 1'b0;
          succ_hit_d  = 1'b0;
          fslot_hit_d = 1'b0;
          st_d        = StOk;
          roff_d      = '0;
          rsz_d       = '0;
          rgrew_d     = 1'b0;
          if (command_i == CmdAlloc && block_size_i == 32'd0) begin
            st_d    = StZero;
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue the next read
        if (rd_cnt_q < CntW'(TableDepth)) begin
          chk_d     = 1'b1;
          chk_idx_d = rd_addr;
          rd_cnt_d  = rd_cnt_q + CntW'(1);
        end
        // examine the entry read last cycle
        if (chk_q) begin
          if (!uv && !uslot_hit_q) begin
            uslot_hit_d = 1'b1;
            uslot_d     = chk_idx_q;
          end
          if (fv && fs >= size_q &&
              (!best_hit_q || fo < best_off_q || (fo == best_off_q && fs < best_sz_q))) begin
            best_hit_d = 1'b1;
            best_idx_d = chk_idx_q;
            best_off_d = fo;
            best_sz_d  = fs;
          end
          if (fv && free_rdata == pack_entry(off_q, size_q)) begin
            fhit_d = 1'b1;
          end
          if (uv && !uhit_q && used_rdata == pack_entry(off_q, size_q)) begin
            uhit_d = 1'b1;
            uidx_d = chk_idx_q;
          end
          if (!fv && !fslot_hit_q) begin
            fslot_hit_d = 1'b1;
            fslot_d     = chk_idx_q;
          end
          if (fv) begin
            if (!pred_hit_q && fend == {1'b0, off_q}) begin
              pred_hit_d = 1'b1;
              pred_idx_d = chk_idx_q;
              pred_off_d = fo;
              pred_sz_d  = fs;
            end else if (!succ_hit_q && {1'b0, fo} == req_end) begin
              succ_hit_d = 1'b1;
              succ_idx_d = chk_idx_q;
              succ_sz_d  = fs;
            end
          end
          if (chk_idx_q == IdxW'(TableDepth - 1)) begin
            state_d = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        state_d = S_RESP;
        if (cmd_q == CmdAlloc) begin
          if (!uslot_hit_q) begin
            st_d = StFull;
          end else if (best_hit_q) begin
            used_we    = 1'b1;
            used_waddr = uslot_q;
            used_wdata = pack_entry(best_off_q, size_q);
            used_valid_d[uslot_q] = 1'b1;
            if (best_sz_q == size_q) begin
              free_valid_d[best_idx_q] = 1'b0;
            end else begin
              free_we    = 1'b1;
              free_waddr = best_idx_q;
              free_wdata = pack_entry(best_off_q + size_q, best_sz_q - size_q);
            end
            roff_d = best_off_q;
            rsz_d  = size_q;
          end else if (app_end[32]) begin
            st_d = StFull;
          end else begin
            used_we    = 1'b1;
            used_waddr = uslot_q;
            used_wdata = pack_entry(heap_end_q, size_q);
            used_valid_d[uslot_q] = 1'b1;
            heap_end_d = app_end[31:0];
            roff_d     = heap_end_q;
            rsz_d      = size_q;
            if (app_end[31:0] > capacity_q) begin
              div_req.start    = 1'b1;
              div_req.dividend = app_end[31:0];
              rgrew_d          = 1'b1;
              state_d          = S_GROW;
            end
          end
        end else begin
          if (fhit_q) begin
            st_d = StAlready;
          end else if (!uhit_q) begin
            st_d = StUnknown;
          end else if (pred_hit_q) begin
            free_we    = 1'b1;
            free_waddr = pred_idx_q;
            free_wdata = pack_entry(pred_off_q, pred_sum);
            if (succ_hit_q) begin
              free_valid_d[succ_idx_q] = 1'b0;
            end
            used_valid_d[uidx_q] = 1'b0;
          end else if (succ_hit_q) begin
            free_we    = 1'b1;
            free_waddr = succ_idx_q;
            free_wdata = pack_entry(off_q, size_q + succ_sz_q);
            used_valid_d[uidx_q] = 1'b0;
          end else if (fslot_hit_q) begin
            free_we    = 1'b1;
            free_waddr = fslot_q;
            free_wdata = pack_entry(off_q, size_q);
            free_valid_d[fslot_q] = 1'b1;
            used_valid_d[uidx_q]  = 1'b0;
          end else begin
            st_d = StFull;
          end
        end
      end

      S_GROW: begin
        // heap_end_q already holds the new end
        if (div_rsp.done) begin
          capacity_d = grow_sum[32] ? 32'hFFFF_FFFF : grow_sum[31:0];
          state_d    = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_off_d   = roff_q;
          out_sz_d    = rsz_q;
          out_grew_d  = rgrew_q;
          out_cap_d   = capacity_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      chk_q        <= 1'b0;
      free_valid_q <= '0;
      used_valid_q <= '0;
      heap_end_q   <= '0;
      capacity_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      chk_q        <= chk_d;
      free_valid_q <= free_valid_d;
      used_valid_q <= used_valid_d;
      heap_end_q   <= heap_end_d;
      capacity_q   <= capacity_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    size_q      <= size_d;
    off_q       <= off_d;
    rd_cnt_q    <= rd_cnt_d;
    chk_idx_q   <= chk_idx_d;
    best_hit_q  <= best_hit_d;
    best_idx_q  <= best_idx_d;
    best_off_q  <= best_off_d;
    best_sz_q   <= best_sz_d;
    uslot_hit_q <= uslot_hit_d;
    uslot_q     <= uslot_d;
    fhit_q      <= fhit_d;
    uhit_q      <= uhit_d;
    uidx_q      <= uidx_d;
    pred_hit_q  <= pred_hit_d;
    pred_idx_q  <= pred_idx_d;
    pred_off_q  <= pred_off_d;
    pred_sz_q   <= pred_sz_d;
    succ_hit_q  <= succ_hit_d;
    succ_idx_q  <= succ_idx_d;
    succ_sz_q   <= succ_sz_d;
    fslot_hit_q <= fslot_hit_d;
    fslot_q     <= fslot_d;
    st_q        <= st_d;
    roff_q      <= roff_d;
    rsz_q       <= rsz_d;
    rgrew_q     <= rgrew_d;
    out_st_q    <= out_st_d;
    out_off_q   <= out_off_d;
    out_sz_q    <= out_sz_d;
    out_grew_q  <= out_grew_d;
    out_cap_q   <= out_cap_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign out_offset_o   = out_off_q;
  assign out_size_o     = out_sz_q;
  assign grew_o         = out_grew_q;
  assign capacity_now_o = out_cap_q;

`include "first_fit_range_allocator_assert.svh"

  // heap end may run ahead of capacity only while growth is in progress
  `FFRA_ASSERT(a_cap_monotonic, capacity_q >= $past(capacity_q), "capacity decreased")
  `FFRA_ASSERT(a_end_within_cap, state_q != S_GROW |-> heap_end_q <= capacity_q, "heap end beyond capacity")
  `FFRA_ASSERT(a_grew_ok, out_valid_o && grew_o |-> status_o == StOk, "growth on a failed request")
  `FFRA_NEVER(a_div_outside_grow, div_rsp.done && state_q != S_GROW, "divider finished unexpectedly")

endmodule
